>>> sv/hbq_pkg.sv
package hbq_pkg;

   localparam int IMAGE_WIDTH  = 256;
   localparam int IMAGE_HEIGHT = 256;
   localparam int CELL_COLUMNS = 64;

   localparam int CELL_WIDTH  = 4;
   localparam int CELL_HEIGHT = 8;
   localparam int ROW_CELLS   = IMAGE_WIDTH / CELL_WIDTH;
   localparam int ACTIVE_CELLS = (ROW_CELLS < CELL_COLUMNS) ? ROW_CELLS : CELL_COLUMNS;
   localparam int ACTIVE_PIXELS = ACTIVE_CELLS * CELL_WIDTH;
   localparam int LAST_LINE = (IMAGE_HEIGHT / CELL_HEIGHT) * CELL_HEIGHT - 1;

   localparam int COL_W  = $clog2(IMAGE_WIDTH);
   localparam int LINE_W = $clog2(IMAGE_HEIGHT);
   localparam int PIX_W  = 8;
   localparam int SUM_W  = 12;
   localparam int IDX_W  = 8;

   typedef struct packed {
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] b;
   } sum_type;

   typedef struct packed {
      sum_type upper;
      sum_type lower;
   } cell_type;

   typedef struct packed {
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
   } avg_type;

endpackage

>>> sv/hbq_cell.sv
module hbq_cell
   import hbq_pkg::*;
(
   input  logic     clock,
   input  logic     shift,
   input  cell_type shift_data,
   input  logic     write,
   input  cell_type write_data,
   output cell_type q
);

   cell_type sums_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         sums_ff <= shift_data;
      end else if (write) begin
         sums_ff <= write_data;
      end
   end

   assign q = sums_ff;

endmodule

>>> sv/hbq_index.sv
module hbq_index
   import hbq_pkg::*;
(
   input  logic             clock,
   input  logic             load,
   input  avg_type          avg,
   output logic [IDX_W-1:0] index
);

   localparam int GRAY_SPREAD = 10;
   localparam int RAMP_LOW    = 8;
   localparam int RAMP_HIGH   = 248;
   localparam int RAMP_BASE   = 232;
   localparam int CUBE_BASE   = 16;
   localparam int CUBE_WHITE  = 231;
   localparam int INDEX_MAX   = 255;
   localparam int CUBE_STEP   = 51;
   localparam int DIV3_MUL    = 683;
   localparam int DIV3_SHIFT  = 11;
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;

   function automatic logic [2:0] cube_digit(input logic [PIX_W-1:0] v);
      logic [2:0] d;
      d = 3'd0;
      if (32'(v) >= CUBE_STEP)     d = 3'd1;
      if (32'(v) >= 2 * CUBE_STEP) d = 3'd2;
      if (32'(v) >= 3 * CUBE_STEP) d = 3'd3;
      if (32'(v) >= 4 * CUBE_STEP) d = 3'd4;
      if (32'(v) >= 5 * CUBE_STEP) d = 3'd5;
      return d;
   endfunction

   logic [PIX_W-1:0] mx;
   logic [PIX_W-1:0] mn;
   logic [9:0]       total;
   logic [19:0]      div3_prod;
   logic             gray_in;

   logic             gray_ff;
   logic [PIX_W-1:0] level_ff;
   logic [2:0]       dr_ff;
   logic [2:0]       dg_ff;
   logic [2:0]       db_ff;

   always_comb begin
      mx = avg.r;
      if (avg.g > mx) mx = avg.g;
      if (avg.b > mx) mx = avg.b;
      mn = avg.r;
      if (avg.g < mn) mn = avg.g;
      if (avg.b < mn) mn = avg.b;
      gray_in   = (mx - mn) < PIX_W'(GRAY_SPREAD);
      total     = 10'(avg.r) + 10'(avg.g) + 10'(avg.b);
      div3_prod = 20'(total) * 20'(DIV3_MUL);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gray_ff  <= gray_in;
         level_ff <= div3_prod[DIV3_SHIFT +: PIX_W];
         dr_ff    <= cube_digit(avg.r);
         dg_ff    <= cube_digit(avg.g);
         db_ff    <= cube_digit(avg.b);
      end
   end

   logic [PIX_W-1:0] ramp_off;
   logic [15:0]      div10_prod;
   logic [8:0]       ramp_val;

   always_comb begin
      ramp_off   = level_ff - PIX_W'(RAMP_LOW);
      div10_prod = 16'(ramp_off) * 16'(DIV10_MUL);
      ramp_val   = 9'(RAMP_BASE) + 9'(div10_prod[15:DIV10_SHIFT]);
      if (gray_ff) begin
         if (32'(level_ff) < RAMP_LOW) begin
            index = IDX_W'(CUBE_BASE);
         end else if (32'(level_ff) > RAMP_HIGH) begin
            index = IDX_W'(CUBE_WHITE);
         end else if (32'(ramp_val) > INDEX_MAX) begin
            index = IDX_W'(INDEX_MAX);
         end else begin
            index = ramp_val[IDX_W-1:0];
         end
      end else begin
         index = IDX_W'(CUBE_BASE) + IDX_W'(36) * IDX_W'(dr_ff)
               + IDX_W'(6) * IDX_W'(dg_ff) + IDX_W'(db_ff);
      end
   end

endmodule

>>> sv/half_block_cell_color_quantizer.sv
// Half-block cell color quantizer. Takes one RGB pixel per clock in raster order and, on the
// last pixel of each complete 4x8 character cell, returns the xterm 256-color indices of the
// cell's upper and lower 4x4 halves, with tlast on the last cell of a character row and tuser
// on the last cell of the frame. The per-cell sums live in a ring of ACTIVE_CELLS cells that
// rotates one place after every fourth pixel of a line, so each pixel needs one add at the
// head cell and the input runs at one beat per clock unless req_tready is low. A result is
// registered in the averages, index and output stages. Pixels keep flowing while a result
// waits; only a cell's completing pixel waits when the three-deep result pipeline is full.
module half_block_cell_color_quantizer
   import hbq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // fore_index[7:0], back_index[15:8]
   output logic        rsp_tlast,   // row_end
   output logic        rsp_tuser    // frame_end
);

   logic [COL_W-1:0]  col_ff,  col_in;
   logic [LINE_W-1:0] line_ff, line_in;

   logic accept;
   logic in_cols;
   logic cell_done;
   logic first_px;
   logic emit_pos;
   logic row_end;
   logic frame_end;

   assign accept    = req_tvalid && req_tready;
   assign in_cols   = 32'(col_ff) < ACTIVE_PIXELS;
   assign cell_done = col_ff[1:0] == 2'd3;
   assign first_px  = (col_ff[1:0] == 2'd0) && (line_ff[1:0] == 2'd0);
   assign emit_pos  = in_cols && cell_done && (line_ff[2:0] == 3'd7)
                    && (32'(line_ff) <= LAST_LINE);
   assign row_end   = 32'(col_ff) == ACTIVE_PIXELS - 1;
   assign frame_end = row_end && (32'(line_ff) == LAST_LINE);

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      if (accept) begin
         if (32'(col_ff) == IMAGE_WIDTH - 1) begin
            col_in = '0;
            if (32'(line_ff) == IMAGE_HEIGHT - 1) begin
               line_in = '0;
            end else begin
               line_in = line_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // accumulator ring, head at index 0
   cell_type ring_q [ACTIVE_CELLS];
   cell_type head_upd;
   sum_type  pix;
   sum_type  half_cur;
   sum_type  half_new;

   always_comb begin
      pix.r    = SUM_W'(req_tdata[7:0]);
      pix.g    = SUM_W'(req_tdata[15:8]);
      pix.b    = SUM_W'(req_tdata[23:16]);
      half_cur = line_ff[2] ? ring_q[0].lower : ring_q[0].upper;
      if (first_px) begin
         half_new = pix;
      end else begin
         half_new.r = half_cur.r + pix.r;
         half_new.g = half_cur.g + pix.g;
         half_new.b = half_cur.b + pix.b;
      end
      head_upd = ring_q[0];
      if (line_ff[2]) begin
         head_upd.lower = half_new;
      end else begin
         head_upd.upper = half_new;
      end
   end

   logic ring_shift;
   logic head_write;

   assign ring_shift = accept && in_cols && cell_done;
   assign head_write = accept && in_cols && !cell_done;

   for (genvar i = 0; i < ACTIVE_CELLS; i++) begin : g_cell
      cell_type shift_data;
      logic     write;
      if (i == ACTIVE_CELLS - 1) begin : g_tail
         assign shift_data = head_upd;
      end else begin : g_mid
         assign shift_data = ring_q[i+1];
      end
      if (i == 0) begin : g_head
         assign write = head_write;
      end else begin : g_rest
         assign write = 1'b0;
      end
      hbq_cell u_cell (
         .clock      (clock),
         .shift      (ring_shift),
         .shift_data (shift_data),
         .write      (write),
         .write_data (head_upd),
         .q          (ring_q[i])
      );
   end

   // result pipeline: averages, index stage, output register
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic out_v_ff, out_v_in;
   logic adv_out, s2_take, s1_take;

   assign adv_out    = !out_v_ff || rsp_tready;
   assign s2_take    = !s2_v_ff || adv_out;
   assign s1_take    = !s1_v_ff || s2_take;
   assign req_tready = !emit_pos || s1_take;

   assign s1_v_in  = (s1_v_ff && !s2_take) || (accept && emit_pos);
   assign s2_v_in  = (s2_v_ff && !adv_out) || (s1_v_ff && s2_take);
   assign out_v_in = (out_v_ff && !rsp_tready) || (s2_v_ff && adv_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         line_ff  <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         line_ff  <= line_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   avg_type s1_up_ff;
   avg_type s1_lo_ff;
   logic    s1_row_ff, s1_frame_ff;
   logic    s2_row_ff, s2_frame_ff;
   logic [IDX_W-1:0] fore_idx, back_idx;
   logic [IDX_W-1:0] fore_ff, back_ff;
   logic    row_ff, frame_ff;

   always_ff @(posedge clock) begin
      if (accept && emit_pos) begin
         s1_up_ff.r  <= head_upd.upper.r[SUM_W-1:4];
         s1_up_ff.g  <= head_upd.upper.g[SUM_W-1:4];
         s1_up_ff.b  <= head_upd.upper.b[SUM_W-1:4];
         s1_lo_ff.r  <= head_upd.lower.r[SUM_W-1:4];
         s1_lo_ff.g  <= head_upd.lower.g[SUM_W-1:4];
         s1_lo_ff.b  <= head_upd.lower.b[SUM_W-1:4];
         s1_row_ff   <= row_end;
         s1_frame_ff <= frame_end;
      end
      if (s1_v_ff && s2_take) begin
         s2_row_ff   <= s1_row_ff;
         s2_frame_ff <= s1_frame_ff;
      end
      if (s2_v_ff && adv_out) begin
         fore_ff  <= fore_idx;
         back_ff  <= back_idx;
         row_ff   <= s2_row_ff;
         frame_ff <= s2_frame_ff;
      end
   end

   hbq_index u_fore (
      .clock (clock),
      .load  (s1_v_ff && s2_take),
      .avg   (s1_up_ff),
      .index (fore_idx)
   );

   hbq_index u_back (
      .clock (clock),
      .load  (s1_v_ff && s2_take),
      .avg   (s1_lo_ff),
      .index (back_idx)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {back_ff, fore_ff};
   assign rsp_tlast  = row_ff;
   assign rsp_tuser  = frame_ff;

endmodule
